>>> hw/rtl/arp_pkg.sv
package arp_pkg;

	localparam int MAX_HELD = 16;
	localparam int IDX_W    = $clog2(MAX_HELD);
	localparam int CNT_W    = $clog2(MAX_HELD + 1);
	localparam int NOTE_W   = 7;
	localparam int HALF_W   = 16;

	localparam logic [HALF_W-1:0] HALF_RESET = 16'd62;
	localparam logic [NOTE_W-1:0] VEL_ON     = 7'd127;
	localparam logic [NOTE_W-1:0] VEL_OFF    = 7'd0;

	typedef logic [NOTE_W-1:0] note_t;

	typedef enum logic [1:0] {
		MODE_NOTE_ON  = 2'd0,
		MODE_NOTE_OFF = 2'd1,
		MODE_PASS     = 2'd2,
		MODE_TICK     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NOTE_ON  = 2'd0,
		KIND_NOTE_OFF = 2'd1,
		KIND_PASS     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ON   = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	// Command broadcast to every cell of the held-note row.
	typedef struct packed {
		logic  ins;
		logic  del;
		note_t key;
	} cell_ctl_t;

	// Note event produced by the player on a tick.
	typedef struct packed {
		logic  valid;
		kind_t kind;
		note_t note;
		note_t vel;
	} play_res_t;

endpackage

>>> hw/rtl/arp_cell.sv
module arp_cell (
	input  logic               clk,
	input  arp_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  logic               left_lt,
	input  arp_pkg::note_t     left_note,
	input  arp_pkg::note_t     right_note,
	output arp_pkg::note_t     note,
	output logic               lt,
	output logic               eq
);
	import arp_pkg::*;

	note_t note_q;

	assign note = note_q;
	assign lt   = occupied && (note_q < ctl.key);
	assign eq   = occupied && (note_q == ctl.key);

	// Cells below the key keep their note; the first cell at or above it takes the key,
	// and the rest take the note from their left neighbour. Removal pulls notes leftwards.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			note_q <= left_lt ? ctl.key : left_note;
		end else if (ctl.del && occupied && !lt) begin
			note_q <= right_note;
		end
	end

endmodule

>>> hw/rtl/arp_player.sv
module arp_player (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick,
	input  logic [arp_pkg::CNT_W-1:0]   held_count,
	input  arp_pkg::note_t              held_notes [arp_pkg::MAX_HELD],
	input  logic [arp_pkg::HALF_W-1:0]  half_period,
	output arp_pkg::play_res_t          res
);
	import arp_pkg::*;

	phase_t            phase_q, phase_d;
	logic [HALF_W-1:0] count_q, count_d;
	logic [CNT_W-1:0]  index_q, index_d;
	note_t             sound_q, sound_d;
	logic [HALF_W-1:0] half_eff;
	logic [HALF_W-1:0] count_dec;
	logic [CNT_W-1:0]  index_sel;
	logic              start;

	assign half_eff  = (half_period == '0) ? HALF_W'(1) : half_period;
	assign count_dec = (count_q != '0) ? count_q - HALF_W'(1) : count_q;
	assign index_sel = (index_q >= held_count) ? '0 : index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			index_q <= '0;
			sound_q <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			index_q <= index_d;
			sound_q <= sound_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		index_d   = index_q;
		sound_d   = sound_q;
		start     = 1'b0;
		res.valid = 1'b0;
		res.kind  = KIND_NOTE_ON;
		res.note  = sound_q;
		res.vel   = VEL_ON;
		if (tick) begin
			case (phase_q)
				PH_IDLE: begin
					start = 1'b1;
				end
				PH_ON: begin
					count_d = count_dec;
					if (count_dec == '0) begin
						phase_d   = PH_GAP;
						count_d   = half_eff;
						res.valid = 1'b1;
						res.kind  = KIND_NOTE_OFF;
						res.vel   = VEL_OFF;
					end
				end
				PH_GAP: begin
					count_d = count_dec;
					start   = (count_dec == '0);
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (start) begin
				if (held_count == '0) begin
					phase_d = PH_IDLE;
					count_d = '0;
				end else begin
					sound_d   = held_notes[index_sel[IDX_W-1:0]];
					index_d   = index_sel + CNT_W'(1);
					phase_d   = PH_ON;
					count_d   = half_eff;
					res.valid = 1'b1;
					res.kind  = KIND_NOTE_ON;
					res.note  = sound_d;
					res.vel   = VEL_ON;
				end
			end
		end
	end

endmodule

>>> hw/rtl/midi_note_arpeggiator_unit.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  s_tuser: mode; s_tdata: code, channel, note, velocity
// m_       out        m_tvalid/m_tready  m_tuser: kind; m_tdata: code, channel, note, velocity
// cfg_     in         cfg_we             cfg_wdata: half period in ticks
//
// Every input beat is handled in the cycle it is accepted; the result, if any, sits in the
// output register from the next cycle. A beat is taken whenever that register is empty or
// being drained, so one beat per cycle is sustained while the output side keeps up.
// The held-note row does its sorted insert or removal in all cells at once, each cell choosing
// between its own note, the key and a neighbour's note. Reset clears the note count, the
// player and the output valid flag; held-note cells start undefined and are never read unset.
module midi_note_arpeggiator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [3:0] event_code, [7:4] channel, [14:8] note,
	                               // [21:15] velocity, [23:22] zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] out_code, [7:4] out_channel, [14:8] out_note,
	                               // [21:15] out_velocity, [23:22] zero
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import arp_pkg::*;

	logic [HALF_W-1:0] half_q;
	logic [CNT_W-1:0]  count_q;
	logic              accept;
	mode_t             mode;
	note_t             key;
	cell_ctl_t         ctl;
	note_t             cell_note [MAX_HELD];
	logic [MAX_HELD-1:0] cell_lt;
	logic [MAX_HELD-1:0] cell_eq;
	logic              found;
	logic              full;
	play_res_t         play;
	logic              m_tvalid_q;
	logic [1:0]        m_tuser_q;
	logic [23:0]       m_tdata_q;

	assign accept = s_tvalid && s_tready;
	assign mode   = mode_t'(s_tuser);
	assign key    = s_tdata[14:8];
	assign found  = |cell_eq;
	assign full   = (count_q == CNT_W'(MAX_HELD));

	// A new note goes in only if it is not already held and there is room; a release
	// acts only on a note that is held.
	assign ctl.ins = accept && (mode == MODE_NOTE_ON) && !found && !full;
	assign ctl.del = accept && (mode == MODE_NOTE_OFF) && found;
	assign ctl.key = key;

	// The output register frees up as its beat leaves, so a new beat can be taken then.
	assign s_tready = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.del) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// The held-note row: cell 0 has nothing on its left, so it always sees "left is
	// below the key"; the last cell has no right neighbour and refills from itself.
	for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
		logic  left_lt;
		note_t left_note;
		note_t right_note;
		if (i == 0) begin : g_first
			assign left_lt   = 1'b1;
			assign left_note = key;
		end else begin : g_inner
			assign left_lt   = cell_lt[i-1];
			assign left_note = cell_note[i-1];
		end
		if (i == MAX_HELD - 1) begin : g_last
			assign right_note = cell_note[i];
		end else begin : g_right
			assign right_note = cell_note[i+1];
		end
		arp_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (CNT_W'(i) < count_q),
			.left_lt    (left_lt),
			.left_note  (left_note),
			.right_note (right_note),
			.note       (cell_note[i]),
			.lt         (cell_lt[i]),
			.eq         (cell_eq[i])
		);
	end

	arp_player u_player (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (accept && (mode == MODE_TICK)),
		.held_count  (count_q),
		.held_notes  (cell_note),
		.half_period (half_q),
		.res         (play)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= (mode == MODE_PASS) || ((mode == MODE_TICK) && play.valid);
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Pass-through beats keep their payload; generated notes carry channel and code zero.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (mode == MODE_PASS) begin
				m_tuser_q <= KIND_PASS;
				m_tdata_q <= {2'b00, s_tdata[21:0]};
			end else begin
				m_tuser_q <= play.kind;
				m_tdata_q <= {2'b00, play.vel, play.note, 4'd0, 4'd0};
			end
		end
	end

endmodule
